// ===== rtl/core/mpsm_pkg.sv =====
package mpsm_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_BUILD  = 2'd2,
    ACT_SCAN   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_PHASE = 2'd2
  } status_t;

  typedef enum logic {
    PH_INSERT = 1'b0,
    PH_BUILT  = 1'b1
  } phase_t;

  localparam int RESULT_CAP = 32;
  localparam int CAP_BITS   = 6;

  // Classified input word as handed from the front queue to the engine.
  typedef struct packed {
    action_t     action;
    logic [7:0]  sym;
    logic [15:0] idx;
    logic        first;
    logic        last;
  } item_t;

endpackage

// ===== rtl/core/mpsm_front.sv =====
module mpsm_front import mpsm_pkg::*; #(
  parameter int ALPHABET   = 256,
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output item_t       head_item,
  output logic        head_valid,
  input  logic        pop
);

  localparam logic [15:0] IDX_MASK =
    (INDEX_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << INDEX_BITS) - 32'd1);

  logic        case_fold;
  item_t       queue [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        push;
  logic [7:0]  folded;
  logic [15:0] rem;
  item_t       cls;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (count != 3'd4);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_valid    = (count != 3'd0);
  assign head_item     = queue[rd_ptr];

  always_comb begin
    folded = s_axis_tdata[7:0];
    if (case_fold && folded >= 8'h41 && folded <= 8'h5A) begin
      folded = folded + 8'h20;
    end
    // reduce into the alphabet, one shifted subtract per bit
    rem = {8'd0, folded};
    for (int i = 7; i >= 0; i--) begin
      if (rem >= (16'(ALPHABET) << i)) begin
        rem = rem - (16'(ALPHABET) << i);
      end
    end
    cls.action = action_t'(s_axis_tuser[1:0]);
    cls.sym    = rem[7:0];
    cls.idx    = s_axis_tdata[23:8] & IDX_MASK;
    cls.first  = s_axis_tuser[2];
    cls.last   = s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (cfg_valid) begin
        case_fold <= cfg_data;
      end
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'd0, push} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

endmodule

// ===== rtl/core/mpsm_engine.sv =====
module mpsm_engine import mpsm_pkg::*; #(
  parameter int MAX_NODES       = 1024,
  parameter int ALPHABET        = 256,
  parameter int MAX_PATTERN_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       head_item,
  input  logic        head_valid,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int NB  = $clog2(MAX_NODES);
  localparam int SB  = $clog2(ALPHABET);
  localparam int DB  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int GAW = $clog2(MAX_NODES * ALPHABET);
  localparam int GD  = MAX_NODES * ALPHABET;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_EMIT   = 15'h0002,
    S_LOOK   = 15'h0004,
    S_INS    = 15'h0008,
    S_SCHK   = 15'h0010,
    S_WALK   = 15'h0020,
    S_WRD    = 15'h0040,
    S_B_GS   = 15'h0080,
    S_B_GF   = 15'h0100,
    S_B_PV   = 15'h0200,
    S_B_VC   = 15'h0400,
    S_B_WR   = 15'h0800,
    S_B_NEXT = 15'h1000,
    S_B_Q    = 15'h2000,
    S_B_F    = 15'h4000
  } state_t;

  logic [NB-1:0]      goto_mem [GD];
  logic [NB+SB-1:0]   par_mem  [MAX_NODES];
  logic [16:0]        out_mem  [MAX_NODES];
  logic [NB-1:0]      dict_mem [MAX_NODES];
  logic [NB-1:0]      fail_mem [MAX_NODES];
  logic [NB-1:0]      bfs_mem  [MAX_NODES];

  logic [NB-1:0]      goto_q;
  logic [NB+SB-1:0]   par_q;
  logic [16:0]        out_q;
  logic [NB-1:0]      dict_q;
  logic [NB-1:0]      fail_q;
  logic [NB-1:0]      bfs_q;

  state_t             state;
  phase_t             phase;
  logic [NB:0]        cnt;
  logic [NB-1:0]      cursor;
  logic [DB-1:0]      depth;
  logic               broken;
  logic [NB-1:0]      scan_node;
  logic [NB-1:0]      cur;
  logic [NB-1:0]      fnode;
  logic [SB-1:0]      c;
  logic [NB-1:0]      x_reg;
  logic [NB-1:0]      via_reg;
  logic               child_reg;
  logic [NB-1:0]      walk_node;
  logic [CAP_BITS-1:0] n;
  logic [NB-1:0]      head;
  logic [NB-1:0]      tail;
  status_t            st;
  item_t              item;

  logic               out_free;
  logic               emit_now;
  logic [NB-1:0]      cur_eff;
  logic [DB-1:0]      dep_eff;
  logic               brk_eff;
  logic [NB-1:0]      disp_node;
  logic [NB-1:0]      rd_node;
  logic [SB-1:0]      rd_sym;
  logic [GAW-1:0]     goto_raddr;
  logic [GAW-1:0]     goto_waddr;
  logic               goto_we;
  logic [NB-1:0]      goto_wdata;
  logic [NB-1:0]      od_raddr;
  logic               chk_x;
  logic               chk_v;
  logic [NB-1:0]      via_sel;
  logic [NB-1:0]      sc_nd;
  logic [NB-1:0]      dictv;
  logic               w_last;
  logic [NB-1:0]      new_node;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit_now = out_free && ((state == S_EMIT) || (state == S_WALK && out_q[16]));
  assign pop      = (state == S_IDLE) && head_valid;
  assign cur_eff  = head_item.first ? '0 : cursor;
  assign dep_eff  = head_item.first ? '0 : depth;
  assign brk_eff  = head_item.first ? 1'b0 : broken;
  assign new_node = cnt[NB-1:0];

  assign chk_x = (x_reg != '0) && ({1'b0, x_reg} < cnt) && (par_q == {cur, c});
  assign chk_v = (via_reg != '0) && ({1'b0, via_reg} < cnt) && (par_q == {{NB{1'b0}}, c});
  assign via_sel = (cur == '0) ? '0 :
                   (fnode == '0) ? (chk_v ? via_reg : '0) : via_reg;
  assign sc_nd = ((cur != '0) || chk_x) ? x_reg : '0;
  // the root has no output and no dictionary link
  assign dictv  = (via_reg == '0) ? '0 : (out_q[16] ? via_reg : dict_q);
  assign w_last = (dict_q == '0) || (n == CAP_BITS'(RESULT_CAP - 1));

  always_comb begin
    disp_node = (head_item.action == ACT_SCAN) ?
                (head_item.first ? '0 : scan_node) : cur_eff;
    rd_node = cur;
    rd_sym  = c;
    unique case (state)
      S_IDLE: begin
        rd_node = disp_node;
        rd_sym  = head_item.sym[SB-1:0];
      end
      S_B_GF:  rd_node = fnode;
      default: rd_node = cur;
    endcase
    goto_raddr = GAW'(rd_node) * GAW'(ALPHABET) + GAW'(rd_sym);
    goto_waddr = GAW'(cur) * GAW'(ALPHABET) + GAW'(c);

    goto_we    = 1'b0;
    goto_wdata = via_reg;
    if (state == S_INS && !chk_x && cnt != (NB+1)'(MAX_NODES)) begin
      goto_we    = 1'b1;
      goto_wdata = new_node;
    end else if (state == S_B_WR && !child_reg) begin
      goto_we = 1'b1;
    end

    unique case (state)
      S_SCHK:  od_raddr = sc_nd;
      S_B_VC:  od_raddr = via_sel;
      default: od_raddr = walk_node;
    endcase
  end

  always_ff @(posedge clk) begin
    goto_q <= goto_mem[goto_raddr];
    par_q  <= par_mem[goto_q];
    out_q  <= out_mem[od_raddr];
    dict_q <= dict_mem[od_raddr];
    fail_q <= fail_mem[bfs_q];
    bfs_q  <= bfs_mem[head];
    if (goto_we) begin
      goto_mem[goto_waddr] <= goto_wdata;
    end
    if (state == S_INS) begin
      if (chk_x) begin
        if (item.last) begin
          out_mem[x_reg] <= {1'b1, item.idx};
        end
      end else if (cnt != (NB+1)'(MAX_NODES)) begin
        par_mem[new_node] <= {cur, c};
        out_mem[new_node] <= {item.last, item.idx};
      end
    end
    if (state == S_B_WR && child_reg) begin
      fail_mem[x_reg] <= via_reg;
      dict_mem[x_reg] <= dictv;
      bfs_mem[tail]   <= x_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_INSERT;
      cnt           <= (NB+1)'(1);
      cursor        <= '0;
      depth         <= '0;
      broken        <= 1'b0;
      scan_node     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_now) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            item <= head_item;
            unique case (head_item.action)
              ACT_CLEAR: begin
                st        <= STAT_OK;
                state     <= S_EMIT;
                phase     <= PH_INSERT;
                cnt       <= (NB+1)'(1);
                cursor    <= '0;
                depth     <= '0;
                broken    <= 1'b0;
                scan_node <= '0;
              end
              ACT_INSERT: begin
                c <= head_item.sym[SB-1:0];
                if (phase != PH_INSERT) begin
                  st    <= STAT_PHASE;
                  state <= S_EMIT;
                end else if (brk_eff || dep_eff >= DB'(MAX_PATTERN_LEN)) begin
                  st     <= STAT_FULL;
                  state  <= S_EMIT;
                  cursor <= '0;
                  depth  <= head_item.last ? '0 : dep_eff;
                  broken <= !head_item.last;
                end else begin
                  st    <= STAT_OK;
                  cur   <= cur_eff;
                  depth <= dep_eff;
                  state <= S_LOOK;
                end
              end
              ACT_BUILD: begin
                if (phase != PH_INSERT) begin
                  st    <= STAT_PHASE;
                  state <= S_EMIT;
                end else begin
                  st    <= STAT_OK;
                  cur   <= '0;
                  fnode <= '0;
                  c     <= '0;
                  head  <= '0;
                  tail  <= '0;
                  state <= S_B_GS;
                end
              end
              ACT_SCAN: begin
                c <= head_item.sym[SB-1:0];
                if (phase != PH_BUILT) begin
                  st    <= STAT_PHASE;
                  state <= S_EMIT;
                end else begin
                  st    <= STAT_OK;
                  cur   <= disp_node;
                  state <= S_LOOK;
                end
              end
              default: begin
                st    <= STAT_OK;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tdata  <= '0;
            m_axis_tuser  <= {st, 1'b0};
            m_axis_tlast  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_LOOK: begin
          x_reg <= goto_q;
          state <= (item.action == ACT_SCAN) ? S_SCHK : S_INS;
        end
        S_INS: begin
          state <= S_EMIT;
          if (chk_x) begin
            cursor <= item.last ? '0 : x_reg;
            depth  <= item.last ? '0 : depth + DB'(1);
            broken <= 1'b0;
          end else if (cnt == (NB+1)'(MAX_NODES)) begin
            st     <= STAT_FULL;
            cursor <= '0;
            depth  <= item.last ? '0 : depth;
            broken <= !item.last;
          end else begin
            cnt    <= cnt + (NB+1)'(1);
            cursor <= item.last ? '0 : new_node;
            depth  <= item.last ? '0 : depth + DB'(1);
            broken <= 1'b0;
          end
        end
        S_SCHK: begin
          scan_node <= sc_nd;
          walk_node <= sc_nd;
          n         <= '0;
          state     <= (sc_nd == '0) ? S_EMIT : S_WALK;
        end
        S_WALK: begin
          if (out_q[16]) begin
            if (out_free) begin
              m_axis_tdata  <= out_q[15:0];
              m_axis_tuser  <= {STAT_OK, 1'b1};
              m_axis_tlast  <= w_last;
              n             <= n + CAP_BITS'(1);
              walk_node     <= dict_q;
              state         <= w_last ? S_IDLE : S_WRD;
            end
          end else if (dict_q == '0) begin
            state <= S_EMIT;
          end else begin
            walk_node <= dict_q;
            state     <= S_WRD;
          end
        end
        S_WRD: state <= S_WALK;
        S_B_GS: state <= S_B_GF;
        S_B_GF: begin
          x_reg <= goto_q;
          state <= S_B_PV;
        end
        S_B_PV: begin
          child_reg <= chk_x;
          via_reg   <= goto_q;
          state     <= S_B_VC;
        end
        S_B_VC: begin
          via_reg <= via_sel;
          state   <= S_B_WR;
        end
        S_B_WR: begin
          if (child_reg) begin
            tail <= tail + NB'(1);
          end
          if (c == SB'(ALPHABET - 1)) begin
            state <= S_B_NEXT;
          end else begin
            c     <= c + SB'(1);
            state <= S_B_GS;
          end
        end
        S_B_NEXT: begin
          if (head == tail) begin
            phase <= PH_BUILT;
            state <= S_EMIT;
          end else begin
            state <= S_B_Q;
          end
        end
        S_B_Q: begin
          cur   <= bfs_q;
          head  <= head + NB'(1);
          state <= S_B_F;
        end
        S_B_F: begin
          fnode <= fail_q;
          c     <= '0;
          state <= S_B_GS;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/multi_pattern_string_matcher.sv =====
// Aho-Corasick matcher. Words enter a four-deep queue that folds case and
// reduces bytes into the alphabet; an engine behind it runs one word at a
// time against the goto memory and the per-node memories, and holds its
// answer in an output register. An insert reads the goto memory and then
// the parent memory; a scan byte reads those and then the output memory,
// once per node on the dictionary chain. Build visits each node of the
// trie in breadth-first order, one goto row entry at a time. A stalled
// output holds the engine. Every word yields at least one result; a scan
// yields one per pattern found, deepest first, up to 32.
module multi_pattern_string_matcher import mpsm_pkg::*; #(
  parameter int MAX_NODES       = 1024,
  parameter int ALPHABET        = 256,
  parameter int INDEX_BITS      = 16,
  parameter int MAX_PATTERN_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte, pattern_index
  input  logic [2:0]  s_axis_tuser,  // action, first
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // match_pattern
  output logic [2:0]  m_axis_tuser,  // match_valid, status
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  item_t head_item;
  logic  head_valid;
  logic  pop;

  mpsm_front #(
    .ALPHABET   (ALPHABET),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .head_item     (head_item),
    .head_valid    (head_valid),
    .pop           (pop)
  );

  mpsm_engine #(
    .MAX_NODES       (MAX_NODES),
    .ALPHABET        (ALPHABET),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .head_item     (head_item),
    .head_valid    (head_valid),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== tb/tb_multi_pattern_string_matcher.sv =====
module tb_multi_pattern_string_matcher;
  import mpsm_pkg::*;

  localparam int NODES     = 1024;
  localparam int ALPHA     = 256;
  localparam int PLEN      = 32;
  localparam int WDOG_MAX  = 200000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // data_byte, pattern_index
  logic [2:0]  s_axis_tuser;  // action, first
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;  // match_pattern
  logic [2:0]  m_axis_tuser;  // match_valid, status
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  multi_pattern_string_matcher dut (.*);

  typedef struct {
    bit        hit;
    bit [15:0] pat;
    bit        tail;
    status_t   st;
  } match_t;

  match_t    match_q[$];
  int        errors;
  int        words_sent;
  int        matches_seen;
  int        idle_cycles;
  bit        calm;

  // shadow automaton
  bit [9:0]  trie_next [NODES*ALPHA];
  bit [9:0]  fail_of [NODES];
  bit        is_end [NODES];
  bit [15:0] end_id [NODES];
  bit [9:0]  dict_of [NODES];
  bit [9:0]  bfs [NODES];
  int        node_total;
  bit [9:0]  ins_node;
  int        ins_len;
  bit        ins_dead;
  bit [9:0]  text_node;
  phase_t    mode;
  bit        fold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit [7:0] fold_byte(bit [7:0] b);
    if (fold && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  function automatic void fresh_node(int n);
    for (int c = 0; c < ALPHA; c++) trie_next[n*ALPHA + c] = '0;
    fail_of[n] = '0;
    is_end[n]  = 1'b0;
    end_id[n]  = '0;
    dict_of[n] = '0;
  endfunction

  function automatic void wipe_trie();
    fresh_node(0);
    node_total = 1;
    ins_node   = '0;
    ins_len    = 0;
    ins_dead   = 1'b0;
    text_node  = '0;
    mode       = PH_INSERT;
  endfunction

  function automatic status_t add_pattern_byte(bit [7:0] b, bit [15:0] idx, bit f, bit l);
    status_t st;
    int      slot;
    bit [9:0] nxt;
    st = STAT_OK;
    if (f) begin
      ins_node = '0; ins_len = 0; ins_dead = 1'b0;
    end
    if (ins_dead) st = STAT_FULL;
    else if (ins_len >= PLEN) begin
      ins_dead = 1'b1; st = STAT_FULL;
    end else begin
      slot = int'(ins_node) * ALPHA + int'(fold_byte(b));
      nxt  = trie_next[slot];
      if (nxt == 0) begin
        if (node_total >= NODES) begin
          ins_dead = 1'b1; st = STAT_FULL;
        end else begin
          nxt = node_total[9:0];
          node_total++;
          fresh_node(int'(nxt));
          trie_next[slot] = nxt;
        end
      end
      if (!ins_dead) begin
        ins_node = nxt; ins_len++;
      end
    end
    if (l) begin
      if (!ins_dead) begin
        is_end[ins_node] = 1'b1;
        end_id[ins_node] = idx;
      end
      ins_node = '0; ins_len = 0; ins_dead = 1'b0;
    end
    return st;
  endfunction

  function automatic void link_trie();
    int       head, tl;
    bit [9:0] s, f, nxt, via;
    head = 0; tl = 0;
    for (int c = 0; c < ALPHA; c++) begin
      nxt = trie_next[c];
      if (nxt != 0 && tl < NODES) begin
        fail_of[nxt] = '0; dict_of[nxt] = '0; bfs[tl++] = nxt;
      end
    end
    while (head < tl) begin
      s = bfs[head++];
      f = fail_of[s];
      for (int c = 0; c < ALPHA; c++) begin
        nxt = trie_next[int'(s)*ALPHA + c];
        via = trie_next[int'(f)*ALPHA + c];
        if (nxt != 0) begin
          fail_of[nxt] = via;
          dict_of[nxt] = is_end[via] ? via : dict_of[via];
          if (tl < NODES) bfs[tl++] = nxt;
        end else begin
          trie_next[int'(s)*ALPHA + c] = via;
        end
      end
    end
    mode = PH_BUILT;
  endfunction

  function automatic void push_match(bit hit, bit [15:0] pat, bit tail, status_t st);
    match_t m;
    m.hit = hit; m.pat = pat; m.tail = tail; m.st = st;
    match_q.push_back(m);
  endfunction

  function automatic void predict_word(action_t a, bit [7:0] b, bit [15:0] idx, bit f, bit l);
    status_t  st;
    bit [9:0] node;
    int       n;
    st = STAT_OK;
    case (a)
      ACT_SCAN: begin
        if (mode == PH_BUILT) begin
          if (f) text_node = '0;
          text_node = trie_next[int'(text_node)*ALPHA + int'(fold_byte(b))];
          node = text_node;
          n = 0;
          for (int i = 0; i <= PLEN && node != 0 && n < RESULT_CAP; i++) begin
            if (is_end[node]) begin
              push_match(1'b1, end_id[node], 1'b0, STAT_OK);
              n++;
            end
            node = dict_of[node];
          end
          if (n == 0) push_match(1'b0, '0, 1'b1, STAT_OK);
          else match_q[match_q.size()-1].tail = 1'b1;
          return;
        end
        st = STAT_PHASE;
      end
      ACT_CLEAR:  wipe_trie();
      ACT_INSERT: st = (mode == PH_INSERT) ? add_pattern_byte(b, idx, f, l) : STAT_PHASE;
      default: begin
        if (mode == PH_INSERT) link_trie();
        else st = STAT_PHASE;
      end
    endcase
    push_match(1'b0, '0, 1'b1, st);
  endfunction

  function automatic bit idle_now();
    return !calm && $urandom_range(99) < 34;
  endfunction

  task automatic send_word(action_t a, bit [7:0] b, bit [15:0] idx, bit f, bit l);
    if (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (idle_now());
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, b};
    s_axis_tuser  <= {f, a};
    s_axis_tlast  <= l;
    do @(posedge clk); while (!s_axis_tready);
    predict_word(a, b, idx, f, l);
    words_sent++;
  endtask

  // hold off until every expected match has been seen
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_fold(bit v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fold = v;
  endtask

  task automatic insert_str(string s, bit [15:0] idx);
    for (int i = 0; i < s.len(); i++)
      send_word(ACT_INSERT, s[i], idx, i == 0, i == s.len() - 1);
  endtask

  task automatic scan_str(string s);
    for (int i = 0; i < s.len(); i++)
      send_word(ACT_SCAN, s[i], 16'($urandom_range(65535)), i == 0,
                1'($urandom_range(1)));
  endtask

  function automatic bit [7:0] pick_byte();
    string pool;
    pool = "abAB";
    if ($urandom_range(99) < 85) return pool[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  task automatic test_basic_dictionary();
    write_fold(1'b0);
    send_word(ACT_SCAN, "x", 16'h0, 1'b1, 1'b0);      // scan before build
    send_word(ACT_CLEAR, 8'h00, 16'h0, 1'b0, 1'b0);
    insert_str("he", 16'h0001);
    insert_str("she", 16'hFFFF);
    insert_str("his", 16'h0000);
    insert_str("hers", 16'h1234);
    insert_str("he", 16'h0005);                         // duplicate, later id wins
    send_word(ACT_INSERT, 8'hFF, 16'hAAAA, 1'b0, 1'b0); // no first mark after a last
    send_word(ACT_INSERT, 8'h00, 16'h5555, 1'b0, 1'b1);
    send_word(ACT_BUILD, 8'h00, 16'h0, 1'b0, 1'b0);
    send_word(ACT_BUILD, 8'h00, 16'h0, 1'b0, 1'b0);    // already built
    send_word(ACT_INSERT, "q", 16'h0, 1'b1, 1'b1);      // wrong phase
    scan_str("ushers");
    send_word(ACT_SCAN, 8'hFF, 16'h0, 1'b1, 1'b0);
    send_word(ACT_SCAN, 8'h00, 16'h0, 1'b0, 1'b0);
    write_fold(1'b1);
    scan_str("SHE");
  endtask

  // a, aa, ... gives a dictionary chain several deep; the pattern of
  // PLEN + 1 bytes runs past the length limit and is not stored
  task automatic test_chain_and_length();
    write_fold(1'b1);
    send_word(ACT_CLEAR, 8'h00, 16'h0, 1'b0, 1'b0);
    for (int n = 1; n <= 5; n++)
      for (int i = 0; i < n; i++)
        send_word(ACT_INSERT, (i % 2) ? "A" : "a", n[15:0], i == 0, i == n - 1);
    for (int i = 0; i <= PLEN; i++)
      send_word(ACT_INSERT, "a", 16'h00FF, i == 0, i == PLEN);
    send_word(ACT_BUILD, 8'h00, 16'h0, 1'b0, 1'b0);
    for (int i = 0; i < 7; i++)
      send_word(ACT_SCAN, "a", 16'h0, i == 0, 1'b0);
    write_fold(1'b0);
    send_word(ACT_SCAN, "A", 16'h0, 1'b0, 1'b0);
  endtask

  task automatic test_random_round(bit f);
    int npat, plen;
    write_fold(f);
    send_word(ACT_CLEAR, 8'($urandom_range(255)), 16'($urandom_range(65535)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
    npat = $urandom_range(3, 6);
    for (int p = 0; p < npat; p++) begin
      plen = $urandom_range(1, 5);
      for (int i = 0; i < plen; i++)
        send_word(ACT_INSERT, pick_byte(), 16'($urandom_range(65535)),
                  (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                  i == plen - 1);
      if ($urandom_range(5) == 0)
        send_word(ACT_SCAN, pick_byte(), 16'($urandom_range(65535)), 1'b1, 1'b0);
    end
    send_word(ACT_BUILD, 8'($urandom_range(255)), 16'($urandom_range(65535)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
    for (int i = 0; i < 14; i++) begin
      if ($urandom_range(15) == 0)
        send_word($urandom_range(1) ? ACT_INSERT : ACT_BUILD, 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      else
        send_word(ACT_SCAN, pick_byte(), 16'($urandom_range(65535)),
                  $urandom_range(9) == 0, 1'($urandom_range(1)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || $urandom_range(99) >= 34;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (match_q.size() == 0) begin
        $error("unexpected match word: pattern %0h", m_axis_tdata);
        errors++;
      end else begin
        match_t m;
        m = match_q.pop_front();
        matches_seen += m.hit;
        if (m_axis_tuser[0] !== m.hit) begin
          $error("match_valid: expected %0d, got %0d", m.hit, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata !== m.pat) begin
          $error("match_pattern: expected %0h, got %0h", m.pat, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== m.tail) begin
          $error("last_result: expected %0d, got %0d", m.tail, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser[2:1] !== m.st) begin
          $error("status: expected %0d, got %0d", m.st, m_axis_tuser[2:1]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; words_sent = 0; matches_seen = 0;
    calm = 1'b0; fold = 1'b0;
    wipe_trie();
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0; s_axis_tlast = 1'b0;
    cfg_valid = 1'b0; cfg_data = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_dictionary();
    test_chain_and_length();
    test_random_round(1'b0);
    calm = 1'b1;
    test_random_round(1'b1);
    calm = 1'b0;
    test_random_round(1'b1);
    test_random_round(1'b0);
    drain();
    repeat (50) @(posedge clk);
    $display("covered clear/insert/build/scan, wrong phase, long pattern, dictionary");
    $display("chains and case folding: %0d words, %0d matches", words_sent,
             matches_seen);
    if (errors == 0 && match_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mpsm_pkg.sv
rtl/core/mpsm_front.sv
rtl/core/mpsm_engine.sv
rtl/core/multi_pattern_string_matcher.sv
tb/tb_multi_pattern_string_matcher.sv
